[rtl/core/csq_pkg.sv]
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types, constants and the DAC word function of the chord step
// sequencer.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int STEP_COUNT_DEF  = 16;
    localparam int CHORD_COUNT_DEF = 8;

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 4;
    localparam int CELL_W  = 3;
    localparam int NOTE_W  = 7;
    localparam int GATE_W  = 7;
    localparam int CNT_W   = 20;
    localparam int ACC_W   = 27;
    localparam int WORD_W  = 16;
    localparam int CODE_W  = 12;
    localparam int POS_W   = 4;

    localparam int TICKS_RESET  = 3920;
    localparam int GATE_RESET   = 50;
    localparam int TICK_WEIGHT  = 100;
    localparam int SLOT_SPAN    = 16;
    localparam int CELL_SPAN    = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [ACC_W-1:0] GATE_X_RESET = ACC_W'(TICKS_RESET * GATE_RESET);

    localparam int LOW_BASE    = 48;
    localparam int SECOND_BASE = 43;
    localparam int THIRD_BASE  = 40;
    localparam int HIGH_BASE   = 36;
    localparam int CHORD_STEP  = 4;

    localparam int NOTE_BASE     = 24;
    localparam int CODE_SAT_SPAN = 60;
    localparam int COARSE_MUL    = 68;
    localparam int FINE_MUL      = 137;
    localparam int FINE_SHIFT    = 11;

    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 3'd0,
        OP_START_STOP  = 3'd1,
        OP_PRESS       = 3'd2,
        OP_RELEASE     = 3'd3,
        OP_WRITE_CHORD = 3'd4,
        OP_WRITE_STEP  = 3'd5
    } csq_op_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SLOT_W-1:0] slot;
        logic [CELL_W-1:0] cell_id;
        logic [NOTE_W-1:0] note_low;
        logic [NOTE_W-1:0] note_second;
        logic [NOTE_W-1:0] note_third;
        logic [NOTE_W-1:0] note_high;
        logic [GATE_W-1:0] gate_percent;
    } csq_item_t;

    typedef struct packed {
        logic              gate_level;
        logic [POS_W-1:0]  step_position;
        logic [CELL_W-1:0] active_cell;
        logic              running;
        logic              chord_update;
        logic [WORD_W-1:0] dac_word_first;
        logic [WORD_W-1:0] dac_word_second;
        logic [WORD_W-1:0] dac_word_third;
        logic [WORD_W-1:0] dac_word_fourth;
    } csq_result_t;

    typedef struct packed {
        logic [NOTE_W-1:0] low;
        logic [NOTE_W-1:0] second;
        logic [NOTE_W-1:0] third;
        logic [NOTE_W-1:0] high;
    } csq_chord_t;

    // code = floor((note-24)*1024/15) = 68*n + floor(4*n/15), saturated
    function automatic logic [WORD_W-1:0] dac_cmd_word(input logic [NOTE_W-1:0] note,
                                                       input logic chan_b);
        logic [NOTE_W-1:0] n;
        logic [12:0]       coarse;
        logic [16:0]       fine;
        logic [CODE_W-1:0] code;
        n      = note - NOTE_W'(NOTE_BASE);
        coarse = 13'(n) * 13'(COARSE_MUL);
        fine   = 17'({n, 2'b00}) * 17'(FINE_MUL);
        if (note < NOTE_W'(NOTE_BASE)) begin
            code = '0;
        end else if (n >= NOTE_W'(CODE_SAT_SPAN)) begin
            code = {CODE_W{1'b1}};
        end else begin
            code = CODE_W'(coarse + 13'(fine[16:FINE_SHIFT]));
        end
        return {chan_b, 1'b0, 1'b1, 1'b1, code};
    endfunction

endpackage

[rtl/core/csq_in_reg.sv]
// ----------------------------------------------------------------------------
// csq_in_reg
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module csq_in_reg
    import csq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  csq_item_t item,
    input  logic      advance,
    output logic      hold_valid,
    output csq_item_t hold_item
);

    logic      valid_reg;
    csq_item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item;
        end
    end

endmodule

[rtl/core/csq_out_reg.sv]
// ----------------------------------------------------------------------------
// csq_out_reg
// Result register: holds one result beat while the receiver stalls.
// ----------------------------------------------------------------------------
module csq_out_reg
    import csq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  csq_result_t result,
    output logic        space,
    output logic        out_valid,
    input  logic        out_stall,
    output csq_result_t out_result
);

    logic        valid_reg;
    csq_result_t result_reg;

    assign space      = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

[rtl/core/csq_core.sv]
// ----------------------------------------------------------------------------
// csq_core
// Sequencer state and the single-pass update for one item: tick counter,
// gate timing, step advance, chord and progression tables, DAC words.
// ----------------------------------------------------------------------------
module csq_core
    import csq_pkg::*;
#(
    parameter int STEP_COUNT  = STEP_COUNT_DEF,
    parameter int CHORD_COUNT = CHORD_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              fire,
    input  csq_item_t         item,
    output csq_result_t       result
);

    localparam int SW = $clog2(STEP_COUNT);
    localparam int CW = $clog2(CHORD_COUNT);

    logic              playing_reg,  playing_next;
    logic [CNT_W-1:0]  tps_reg,      tps_next;
    logic [CNT_W-1:0]  tick_cnt_reg, tick_cnt_next;
    logic [ACC_W-1:0]  acc_reg,      acc_next;
    logic [ACC_W-1:0]  gate_x_reg,   gate_x_next;
    logic [SW-1:0]     step_reg,     step_next;
    logic [CW-1:0]     chord_reg,    chord_next;
    logic              gate_reg,     gate_next;

    csq_chord_t        notes_reg [CHORD_COUNT];
    logic [GATE_W-1:0] cgate_reg [CHORD_COUNT];
    logic [CW-1:0]     prog_reg  [STEP_COUNT];

    logic [SW-1:0]     step_inc;
    logic [SW-1:0]     prog_addr;
    logic [CW-1:0]     prog_rd;
    logic [CW-1:0]     gate_addr;
    logic [GATE_W-1:0] gate_rd;
    logic [CNT_W-1:0]  mul_tps;
    logic [ACC_W-1:0]  gate_x_new;
    logic [CNT_W-1:0]  cnt_inc;
    logic [ACC_W-1:0]  acc_inc;
    logic [ACC_W:0]    acc_hi;
    logic              gate_hit;
    logic              step_hit;
    logic [CW-1:0]     words_addr;
    csq_chord_t        notes_rd;
    logic [SW-1:0]     slot_step;
    logic [CW-1:0]     slot_chord;
    logic [CW-1:0]     cell_chord;
    logic              upd;
    logic              is_ss;

    always_comb
    begin
        slot_step  = '0;
        slot_chord = '0;
        cell_chord = '0;
        for (int i = 0; i < SLOT_SPAN; i++)
        begin
            if (item.slot == SLOT_W'(i))
            begin
                slot_step  = SW'(i % STEP_COUNT);
                slot_chord = CW'(i % CHORD_COUNT);
            end
        end
        for (int i = 0; i < CELL_SPAN; i++)
        begin
            if (item.cell_id == CELL_W'(i))
            begin
                cell_chord = CW'(i % CHORD_COUNT);
            end
        end
    end

    assign is_ss      = fire && (item.opcode == OP_START_STOP);
    assign step_inc   = (step_reg == SW'(STEP_COUNT - 1)) ? '0 : step_reg + SW'(1);
    assign prog_addr  = is_ss ? '0 : step_inc;
    assign prog_rd    = prog_reg[prog_addr];
    assign gate_addr  = cfg_wr_en ? chord_reg : prog_rd;
    assign gate_rd    = cgate_reg[gate_addr];
    assign mul_tps    = cfg_wr_en ? cfg_wr_data : tps_reg;
    assign gate_x_new = ACC_W'(mul_tps) * ACC_W'(gate_rd);

    // acc tracks 100 * count; gate drops where floor(gate_x/100) meets the count
    assign cnt_inc  = tick_cnt_reg + CNT_W'(1);
    assign acc_inc  = (tick_cnt_reg == CNT_MAX) ? '0 : acc_reg + ACC_W'(TICK_WEIGHT);
    assign acc_hi   = {1'b0, acc_inc} + (ACC_W + 1)'(TICK_WEIGHT);
    assign gate_hit = (gate_x_reg >= acc_inc) &&
                      ((cnt_inc == CNT_MAX) || ({1'b0, gate_x_reg} < acc_hi));
    assign step_hit = (cnt_inc == tps_reg);

    assign words_addr = (item.opcode == OP_PRESS) ? cell_chord : prog_rd;
    assign notes_rd   = notes_reg[words_addr];

    always_comb
    begin
        playing_next  = playing_reg;
        tps_next      = tps_reg;
        tick_cnt_next = tick_cnt_reg;
        acc_next      = acc_reg;
        gate_x_next   = gate_x_reg;
        step_next     = step_reg;
        chord_next    = chord_reg;
        gate_next     = gate_reg;
        upd           = 1'b0;
        if (fire)
        begin
            case (item.opcode)
                OP_TICK:
                begin
                    if (playing_reg)
                    begin
                        tick_cnt_next = cnt_inc;
                        acc_next      = acc_inc;
                        if (gate_hit)
                        begin
                            gate_next = 1'b0;
                        end
                        if (step_hit)
                        begin
                            tick_cnt_next = '0;
                            acc_next      = '0;
                            step_next     = step_inc;
                            chord_next    = prog_rd;
                            gate_x_next   = gate_x_new;
                            gate_next     = 1'b1;
                            upd           = 1'b1;
                        end
                    end
                end
                OP_START_STOP:
                begin
                    playing_next  = !playing_reg;
                    tick_cnt_next = '0;
                    acc_next      = '0;
                    step_next     = '0;
                    gate_x_next   = gate_x_new;
                    gate_next     = !playing_reg;
                end
                OP_PRESS:
                begin
                    chord_next = cell_chord;
                    gate_next  = 1'b1;
                    upd        = 1'b1;
                end
                OP_RELEASE:
                begin
                    if (!playing_reg)
                    begin
                        gate_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cfg_wr_en)
        begin
            tps_next      = cfg_wr_data;
            tick_cnt_next = '0;
            acc_next      = '0;
            gate_x_next   = gate_x_new;
        end
    end

    always_comb
    begin
        result.gate_level      = gate_next;
        result.step_position   = POS_W'(step_next);
        result.active_cell     = CELL_W'(chord_next);
        result.running         = playing_next;
        result.chord_update    = upd;
        result.dac_word_first  = '0;
        result.dac_word_second = '0;
        result.dac_word_third  = '0;
        result.dac_word_fourth = '0;
        if (upd)
        begin
            result.dac_word_first  = dac_cmd_word(notes_rd.high,   1'b0);
            result.dac_word_second = dac_cmd_word(notes_rd.third,  1'b1);
            result.dac_word_third  = dac_cmd_word(notes_rd.second, 1'b0);
            result.dac_word_fourth = dac_cmd_word(notes_rd.low,    1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg  <= 1'b0;
            tps_reg      <= CNT_W'(TICKS_RESET);
            tick_cnt_reg <= '0;
            acc_reg      <= '0;
            gate_x_reg   <= GATE_X_RESET;
            step_reg     <= '0;
            chord_reg    <= '0;
            gate_reg     <= 1'b0;
        end
        else
        begin
            playing_reg  <= playing_next;
            tps_reg      <= tps_next;
            tick_cnt_reg <= tick_cnt_next;
            acc_reg      <= acc_next;
            gate_x_reg   <= gate_x_next;
            step_reg     <= step_next;
            chord_reg    <= chord_next;
            gate_reg     <= gate_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHORD_COUNT; i++)
            begin
                notes_reg[i].low    <= NOTE_W'(LOW_BASE    + CHORD_STEP * i);
                notes_reg[i].second <= NOTE_W'(SECOND_BASE + CHORD_STEP * i);
                notes_reg[i].third  <= NOTE_W'(THIRD_BASE  + CHORD_STEP * i);
                notes_reg[i].high   <= NOTE_W'(HIGH_BASE   + CHORD_STEP * i);
                cgate_reg[i]        <= GATE_W'(GATE_RESET);
            end
            for (int i = 0; i < STEP_COUNT; i++)
            begin
                prog_reg[i] <= CW'(i % CHORD_COUNT);
            end
        end
        else if (fire)
        begin
            if (item.opcode == OP_WRITE_CHORD)
            begin
                notes_reg[slot_chord].low    <= item.note_low;
                notes_reg[slot_chord].second <= item.note_second;
                notes_reg[slot_chord].third  <= item.note_third;
                notes_reg[slot_chord].high   <= item.note_high;
                cgate_reg[slot_chord]        <= item.gate_percent;
            end
            if (item.opcode == OP_WRITE_STEP)
            begin
                prog_reg[slot_step] <= cell_chord;
            end
        end
    end

    a_acc_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg == ACC_W'(tick_cnt_reg) * ACC_W'(TICK_WEIGHT))
        else $error("tick weight accumulator out of step with tick count");

    a_stopped_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cfg_wr_en && (item.opcode == OP_TICK) && !playing_reg
        |=> $stable(tick_cnt_reg) && $stable(step_reg) && $stable(gate_reg))
        else $error("tick changed state while stopped");

    a_step_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cfg_wr_en && (item.opcode == OP_TICK) && upd
        |=> (tick_cnt_reg == '0) && gate_reg)
        else $error("step advance left count or gate wrong");

    a_update_raises_gate: assert property (@(posedge clk) disable iff (!rst_n)
        fire && upd |-> result.gate_level && !(result.dac_word_first[12] == 1'b0))
        else $error("chord update without gate");

endmodule

[rtl/core/chord_step_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// chord_step_sequencer_unit
// Chord step sequencer: tick counting, gate timing, step advance and
// four DAC command words per chord change.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: tick,
//   start/stop, press, release, chord write or step write.
//   Output channel (out_valid / out_stall) returns exactly one result beat
//   per command: gate, step, chord, run flag and, on a chord change, the
//   four DAC words (zero otherwise).
//   cfg_wr_en / cfg_wr_data write ticks_per_step; write only while no
//   command is in flight. A write clears the tick count.
//   Path: a beat accepted into the input register is loaded into the result
//   register once it has space. Throughput: one beat per cycle while the
//   result register has space, set by the single-pass update between the two.
//   Reset: stopped, step 0, chord 0, gate low, default chord and step
//   tables, 3920 ticks per step; no clearing pass.
//   Stall: while out_stall holds a full result register, the input
//   register holds its beat and in_stall rises once it is full.
// ----------------------------------------------------------------------------
module chord_step_sequencer_unit
    import csq_pkg::*;
#(
    parameter int STEP_COUNT  = STEP_COUNT_DEF,
    parameter int CHORD_COUNT = CHORD_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   opcode,
    input  logic [SLOT_W-1:0] slot,
    input  logic [CELL_W-1:0] cell_id,
    input  logic [NOTE_W-1:0] note_low,
    input  logic [NOTE_W-1:0] note_second,
    input  logic [NOTE_W-1:0] note_third,
    input  logic [NOTE_W-1:0] note_high,
    input  logic [GATE_W-1:0] gate_percent,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              gate_level,
    output logic [POS_W-1:0]  step_position,
    output logic [CELL_W-1:0] active_cell,
    output logic              running,
    output logic              chord_update,
    output logic [WORD_W-1:0] dac_word_first,
    output logic [WORD_W-1:0] dac_word_second,
    output logic [WORD_W-1:0] dac_word_third,
    output logic [WORD_W-1:0] dac_word_fourth
);

    csq_item_t   in_item;
    csq_item_t   hold_item;
    logic        hold_valid;
    logic        out_space;
    logic        fire;
    csq_result_t core_result;
    csq_result_t out_result;

    assign in_item.opcode       = opcode;
    assign in_item.slot         = slot;
    assign in_item.cell_id      = cell_id;
    assign in_item.note_low     = note_low;
    assign in_item.note_second  = note_second;
    assign in_item.note_third   = note_third;
    assign in_item.note_high    = note_high;
    assign in_item.gate_percent = gate_percent;

    assign fire = hold_valid && out_space;

    csq_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item       (in_item),
        .advance    (fire),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    csq_core #(
        .STEP_COUNT  (STEP_COUNT),
        .CHORD_COUNT (CHORD_COUNT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (hold_item),
        .result      (core_result)
    );

    csq_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (core_result),
        .space      (out_space),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign gate_level      = out_result.gate_level;
    assign step_position   = out_result.step_position;
    assign active_cell     = out_result.active_cell;
    assign running         = out_result.running;
    assign chord_update    = out_result.chord_update;
    assign dac_word_first  = out_result.dac_word_first;
    assign dac_word_second = out_result.dac_word_second;
    assign dac_word_third  = out_result.dac_word_third;
    assign dac_word_fourth = out_result.dac_word_fourth;

endmodule
